FILE: sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types, constants and helpers for the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_DEPTH  = MAX_FRAMES / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int COUNT_W    = 13;
    localparam int WCNT_W     = COUNT_W - BIT_W;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [BIT_W-1:0]     bitpos_t;
    typedef logic [FRAME_W-1:0]   frame_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [WCNT_W-1:0]    wcnt_t;

    localparam word_t  FULL_WORD         = '1;
    localparam count_t FRAME_COUNT_RESET = COUNT_W'(MAX_FRAMES);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_FRAME = 1'b1;

    typedef struct packed {
        logic   cmd;
        frame_t page_frame;
        logic   page_present;
        logic   page_writable;
        logic   page_user;
        logic   req_kernel;
        logic   req_writable;
    } alloc_req_t;

    typedef struct packed {
        frame_t new_frame;
        logic   new_present;
        logic   new_writable;
        logic   new_user;
        logic   status;
    } alloc_rsp_t;

    // controller to bitmap memory
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
    } ram_req_t;

    // lowest clear bit of a word, binary search over halves
    function automatic bitpos_t lowest_zero(input word_t w);
        word_t   v;
        bitpos_t idx;
        word_t   mask;
        v   = ~w;
        idx = '0;
        for (int lvl = BIT_W - 1; lvl >= 0; lvl--)
        begin
            mask = (word_t'(1) << (1 << lvl)) - word_t'(1);
            if ((v & mask) == '0)
            begin
                v        = v >> (1 << lvl);
                idx[lvl] = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/bfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// frame bitmap store, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module bfa_bitmap_ram
    import bfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ram_req_t ram,
    output word_t    rdata
);

    word_t                mem [MAP_DEPTH];
    word_t                rdata_reg;
    logic [MAP_DEPTH-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ram.wr_en)
        begin
            mem[ram.wr_addr] <= ram.wr_data;
        end
        if (ram.rd_en)
        begin
            rdata_reg <= mem[ram.rd_addr];
        end
    end

    // never-written words read as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram.wr_en)
            begin
                valid_reg[ram.wr_addr] <= 1'b1;
            end
            if (ram.rd_en)
            begin
                rd_valid_reg <= valid_reg[ram.rd_addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rdata_reg : '0;

endmodule

FILE: sv/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// request sequencer: word scan for allocate, read-modify-write for free
// ----------------------------------------------------------------------------
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  alloc_req_t req,
    input  count_t     frame_count,
    input  word_t      rdata,
    output ram_req_t   ram,
    output logic       busy,
    output logic       done,
    output alloc_rsp_t result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_CLR  = 3'b100
    } state_t;

    state_t     state_reg,  state_next;
    alloc_req_t req_reg,    req_next;
    addr_t      scan_reg,   scan_next;
    alloc_rsp_t rsp_reg,    rsp_next;
    logic       done_reg,   done_next;

    wcnt_t   words;
    wcnt_t   limit;
    wcnt_t   scan_plus;
    bitpos_t hit_bit;
    bitpos_t clr_bit;

    // whole words searched, saturated to the store
    assign words     = frame_count[COUNT_W-1:BIT_W];
    assign limit     = (words > WCNT_W'(MAP_DEPTH)) ? WCNT_W'(MAP_DEPTH) : words;
    assign scan_plus = WCNT_W'(scan_reg) + WCNT_W'(1);
    assign hit_bit   = lowest_zero(rdata);
    assign clr_bit   = req_reg.page_frame[BIT_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        scan_next  = scan_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        ram        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    rsp_next = '{new_frame:    req.page_frame,
                                 new_present:  req.page_present,
                                 new_writable: req.page_writable,
                                 new_user:     req.page_user,
                                 status:       STATUS_OK};
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (req.page_frame != '0)
                        begin
                            rsp_next.new_writable = req.req_writable;
                            rsp_next.new_user     = req.req_kernel;
                            done_next             = 1'b1;
                        end
                        else if (limit == '0)
                        begin
                            rsp_next.status = STATUS_NO_FRAME;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            ram.rd_en   = 1'b1;
                            ram.rd_addr = '0;
                            scan_next   = '0;
                            state_next  = ST_SCAN;
                        end
                    end
                    else if (req.page_frame != '0)
                    begin
                        ram.rd_en   = 1'b1;
                        ram.rd_addr = req.page_frame[FRAME_W-1:BIT_W];
                        state_next  = ST_CLR;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rdata != FULL_WORD)
                begin
                    ram.wr_en             = 1'b1;
                    ram.wr_addr           = scan_reg;
                    ram.wr_data           = rdata | (word_t'(1) << hit_bit);
                    rsp_next.new_frame    = {scan_reg, hit_bit};
                    rsp_next.new_present  = 1'b1;
                    rsp_next.new_writable = req_reg.req_writable;
                    rsp_next.new_user     = req_reg.req_kernel;
                    rsp_next.status       = STATUS_OK;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
                else if (scan_plus >= limit)
                begin
                    rsp_next.status = STATUS_NO_FRAME;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    scan_next   = scan_plus[ADDR_W-1:0];
                    ram.rd_en   = 1'b1;
                    ram.rd_addr = scan_plus[ADDR_W-1:0];
                end
            end

            ST_CLR:
            begin
                ram.wr_en          = 1'b1;
                ram.wr_addr        = req_reg.page_frame[FRAME_W-1:BIT_W];
                ram.wr_data        = rdata & ~(word_t'(1) << clr_bit);
                rsp_next.new_frame = '0;
                rsp_next.status    = STATUS_OK;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        scan_reg <= scan_next;
        rsp_reg  <= rsp_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef SYNTHESIS
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither in work nor answered");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram.wr_en |-> (state_reg == ST_SCAN || state_reg == ST_CLR))
        else $error("bitmap write outside scan or clear");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (WCNT_W'(scan_reg) < limit))
        else $error("scan beyond searched words");

    a_no_frame_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && rdata == FULL_WORD) |-> !ram.wr_en)
        else $error("full word written during scan");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_next == ST_IDLE) |-> done_next)
        else $error("work finished without a result");
`endif

endmodule

FILE: sv/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit page frame allocator over a used/free bitmap of 32-bit words
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+---------------------------------
//  request  | start, busy (start & !busy) | req    (alloc_req_t)
//  result   | done strobe, one cycle      | result (alloc_rsp_t)
//  config   | cfg_valid, cfg_ready        | cfg_data (frame_count)
//
//  answers: pass-through requests (allocate on a mapped entry, free of
//  frame 0, allocate with no words to search) answer in the cycle after
//  accept; free reads the word and answers as it writes it back;
//  allocate reads word 0 on accept, then answers on the first word with a
//  clear bit or once all searched words (at most 128 here) are full. the
//  bitmap memory port reads one word per cycle while the next one is requested
//  reset: control state and the per-word valid bits clear at once, so the
//  bitmap reads as all free right after reset with no clearing pass
//  stalls: one request at a time, busy holds off new ones; the result
//  receiver cannot stall, the done strobe is high for one cycle only
//
module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // request word
    input  logic       start,
    output logic       busy,
    input  alloc_req_t req,

    // result word
    output logic       done,
    output alloc_rsp_t result,

    // frame count register
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  count_t     cfg_data
);

    count_t   frame_count_reg;
    ram_req_t ram;
    word_t    rdata;

    // frame count only changes between requests, never at a request accept
    assign cfg_ready = !busy && !start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_count_reg <= cfg_data;
        end
    end

    // sequencer: scans on allocate, read-modify-write on free
    bfa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .frame_count (frame_count_reg),
        .rdata       (rdata),
        .ram         (ram),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    // bitmap store, one read and one write a cycle
    bfa_bitmap_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .ram   (ram),
        .rdata (rdata)
    );

endmodule
